// ===== sv/m3i_pkg.sv =====
package m3i_pkg;

  // Matrix shape and result format
  localparam int unsigned NUM_ELEM = 9;
  localparam int unsigned IDX_W    = 4;
  localparam int unsigned OUT_W    = 48;

  typedef logic [IDX_W-1:0] m3i_idx_t;

  localparam m3i_idx_t LAST_IDX = 4'd8;
  localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};

  // Cofactor k = x*y - z*w, operands as element indices (row*3 + col)
  localparam m3i_idx_t MUL_X [NUM_ELEM] = '{4'd4, 4'd3, 4'd3, 4'd1, 4'd0, 4'd0, 4'd1, 4'd0, 4'd0};
  localparam m3i_idx_t MUL_Y [NUM_ELEM] = '{4'd8, 4'd8, 4'd7, 4'd8, 4'd8, 4'd7, 4'd5, 4'd5, 4'd4};
  localparam m3i_idx_t MUL_Z [NUM_ELEM] = '{4'd7, 4'd6, 4'd6, 4'd7, 4'd6, 4'd6, 4'd4, 4'd3, 4'd3};
  localparam m3i_idx_t MUL_W [NUM_ELEM] = '{4'd5, 4'd5, 4'd4, 4'd2, 4'd2, 4'd1, 4'd2, 4'd2, 4'd1};

  // Cofactors with odd row+col carry a minus sign
  localparam logic [NUM_ELEM-1:0] NEG_MASK = 9'h0AA;

  // Adjugate entry k = i*3+j comes from cofactor j*3+i
  localparam m3i_idx_t TRANSPOSE [NUM_ELEM] = '{4'd0, 4'd3, 4'd6, 4'd1, 4'd4, 4'd7, 4'd2, 4'd5, 4'd8};

  // Sideband that travels through the divider with each quotient
  typedef struct packed {
    m3i_idx_t idx;
    logic     last;
    logic     qneg;
    logic     sing;
  } m3i_tag_t;

endpackage

// ===== sv/m3i_front.sv =====
module m3i_front #(
  parameter int DATA_WIDTH = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic signed [DATA_WIDTH-1:0] a_i [m3i_pkg::NUM_ELEM],
  output logic                         valid_o,
  output logic [2*DATA_WIDTH-1:0]      mag_o [m3i_pkg::NUM_ELEM],
  output logic [m3i_pkg::NUM_ELEM-1:0] sgn_o,
  output logic [3*DATA_WIDTH:0]        dmag_o,
  output logic                         dneg_o,
  output logic                         sing_o
);
  import m3i_pkg::*;

  localparam int D  = DATA_WIDTH;
  localparam int PW = 2 * D;
  localparam int CW = 2 * D + 1;
  localparam int LW = D + 1;
  localparam int HW = CW - LW;
  localparam int DW = 3 * D + 2;
  localparam int GW = 3 * D + 1;

  logic [6:0] v_q;

  logic signed [D-1:0]  a0_q [NUM_ELEM];
  logic signed [PW-1:0] p1_q [NUM_ELEM];
  logic signed [PW-1:0] p2_q [NUM_ELEM];
  logic signed [D-1:0]  r1_q [3];
  logic signed [CW-1:0] c2_q [NUM_ELEM];
  logic signed [D-1:0]  r2_q [3];
  logic signed [D+LW:0] pl3_q [3];
  logic signed [PW-1:0] ph3_q [3];
  logic signed [CW-1:0] c3_q [NUM_ELEM];
  logic signed [DW-1:0] pr4_q [3];
  logic signed [CW-1:0] c4_q [NUM_ELEM];
  logic signed [DW-1:0] det5_q;
  logic [PW-1:0]        mag5_q [NUM_ELEM];
  logic [NUM_ELEM-1:0]  sgn5_q;
  logic [PW-1:0]        mag6_q [NUM_ELEM];
  logic [NUM_ELEM-1:0]  sgn6_q;
  logic [GW-1:0]        dmag6_q;
  logic                 dneg6_q;
  logic                 sing6_q;

  logic signed [LW:0]   lo [3];
  logic signed [HW-1:0] hi [3];
  logic signed [DW-1:0] neg_det;
  logic signed [CW-1:0] neg_c [NUM_ELEM];

  // Valid bits follow the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[5:0], valid_i};
    end
  end

  // Split cofactor into unsigned low part and signed high part
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      lo[j] = $signed({1'b0, c2_q[j][LW-1:0]});
      hi[j] = $signed(c2_q[j][CW-1:LW]);
    end
    neg_det = -det5_q;
    for (int k = 0; k < NUM_ELEM; k++) begin
      neg_c[k] = -c4_q[TRANSPOSE[k]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // stage 0: capture elements
      a0_q <= a_i;
      // stage 1: cofactor products
      for (int k = 0; k < NUM_ELEM; k++) begin
        p1_q[k] <= a0_q[MUL_X[k]] * a0_q[MUL_Y[k]];
        p2_q[k] <= a0_q[MUL_Z[k]] * a0_q[MUL_W[k]];
      end
      for (int j = 0; j < 3; j++) begin
        r1_q[j] <= a0_q[j];
      end
      // stage 2: signed cofactors
      for (int k = 0; k < NUM_ELEM; k++) begin
        if (NEG_MASK[k]) begin
          c2_q[k] <= CW'(p2_q[k]) - CW'(p1_q[k]);
        end else begin
          c2_q[k] <= CW'(p1_q[k]) - CW'(p2_q[k]);
        end
      end
      r2_q <= r1_q;
      // stage 3: partial products of the row-0 expansion
      for (int j = 0; j < 3; j++) begin
        pl3_q[j] <= r2_q[j] * lo[j];
        ph3_q[j] <= r2_q[j] * hi[j];
      end
      c3_q <= c2_q;
      // stage 4: recombine partial products
      for (int j = 0; j < 3; j++) begin
        pr4_q[j] <= (DW'(ph3_q[j]) <<< LW) + DW'(pl3_q[j]);
      end
      c4_q <= c3_q;
      // stage 5: determinant, adjugate magnitude and sign
      det5_q <= pr4_q[0] + pr4_q[1] + pr4_q[2];
      for (int k = 0; k < NUM_ELEM; k++) begin
        sgn5_q[k] <= c4_q[TRANSPOSE[k]][CW-1];
        mag5_q[k] <= c4_q[TRANSPOSE[k]][CW-1] ? neg_c[k][PW-1:0]
                                               : c4_q[TRANSPOSE[k]][PW-1:0];
      end
      // stage 6: determinant magnitude and zero test
      dneg6_q <= det5_q[DW-1];
      dmag6_q <= det5_q[DW-1] ? neg_det[GW-1:0] : det5_q[GW-1:0];
      sing6_q <= (det5_q == '0);
      mag6_q  <= mag5_q;
      sgn6_q  <= sgn5_q;
    end
  end

  assign valid_o = v_q[6];
  assign mag_o   = mag6_q;
  assign sgn_o   = sgn6_q;
  assign dmag_o  = dmag6_q;
  assign dneg_o  = dneg6_q;
  assign sing_o  = sing6_q;

endmodule

// ===== sv/m3i_div.sv =====
module m3i_div #(
  parameter int NUM_W = 48,
  parameter int DEN_W = 49
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  input  m3i_pkg::m3i_tag_t tag_i,
  output logic              valid_o,
  output logic [NUM_W-1:0]  quot_o,
  output m3i_pkg::m3i_tag_t tag_o
);
  import m3i_pkg::*;

  logic             v_q [NUM_W];
  logic [DEN_W-1:0] r_q [NUM_W];
  logic [NUM_W-1:0] n_q [NUM_W];
  logic [DEN_W-1:0] d_q [NUM_W];
  m3i_tag_t         t_q [NUM_W];

  // One restoring step per stage; quotient bits shift in behind the numerator
  for (genvar s = 0; s < NUM_W; s++) begin : g_stage
    logic             vin;
    logic [DEN_W-1:0] rin;
    logic [NUM_W-1:0] nin;
    logic [DEN_W-1:0] din;
    m3i_tag_t         tin;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             take;

    if (s == 0) begin : g_first
      assign vin = valid_i;
      assign rin = '0;
      assign nin = num_i;
      assign din = den_i;
      assign tin = tag_i;
    end else begin : g_next
      assign vin = v_q[s-1];
      assign rin = r_q[s-1];
      assign nin = n_q[s-1];
      assign din = d_q[s-1];
      assign tin = t_q[s-1];
    end

    assign trial = {rin, nin[NUM_W-1]};
    assign take  = (trial >= {1'b0, din});
    assign diff  = trial - {1'b0, din};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en_i) begin
        v_q[s] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[s] <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        n_q[s] <= {nin[NUM_W-2:0], take};
        d_q[s] <= din;
        t_q[s] <= tin;
      end
    end
  end

  assign valid_o = v_q[NUM_W-1];
  assign quot_o  = n_q[NUM_W-1];
  assign tag_o   = t_q[NUM_W-1];

endmodule

// ===== sv/matrix3x3_inverse.sv =====
// Structure: seven front stages, an issue holding register and one bit-per-stage divider.
// The nine adjugate entries issue one per cycle, while a finished result is not stalled, into
// a single shared pipelined divider; a new matrix enters the issue register as the last
// entry of the previous one issues.
// Reset: rst_ni is asynchronous active low and clears all valid bits and the issue
// counter; no clearing pass is needed.
module matrix3x3_inverse #(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [DATA_WIDTH-1:0] a_r0c0_i,
  input  logic signed [DATA_WIDTH-1:0] a_r0c1_i,
  input  logic signed [DATA_WIDTH-1:0] a_r0c2_i,
  input  logic signed [DATA_WIDTH-1:0] a_r1c0_i,
  input  logic signed [DATA_WIDTH-1:0] a_r1c1_i,
  input  logic signed [DATA_WIDTH-1:0] a_r1c2_i,
  input  logic signed [DATA_WIDTH-1:0] a_r2c0_i,
  input  logic signed [DATA_WIDTH-1:0] a_r2c1_i,
  input  logic signed [DATA_WIDTH-1:0] a_r2c2_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [47:0]           inv_r0c0_o,
  output logic signed [47:0]           inv_r0c1_o,
  output logic signed [47:0]           inv_r0c2_o,
  output logic signed [47:0]           inv_r1c0_o,
  output logic signed [47:0]           inv_r1c1_o,
  output logic signed [47:0]           inv_r1c2_o,
  output logic signed [47:0]           inv_r2c0_o,
  output logic signed [47:0]           inv_r2c1_o,
  output logic signed [47:0]           inv_r2c2_o,
  output logic                         singular_o
);
  import m3i_pkg::*;

  localparam int MW  = 2 * DATA_WIDTH;
  localparam int GW  = 3 * DATA_WIDTH + 1;
  localparam int NW  = MW + FRAC_BITS;
  localparam int QXW = (NW > OUT_W) ? NW : OUT_W + 1;

  logic signed [DATA_WIDTH-1:0] a_vec [NUM_ELEM];

  logic                f_valid;
  logic [MW-1:0]       f_mag [NUM_ELEM];
  logic [NUM_ELEM-1:0] f_sgn;
  logic [GW-1:0]       f_dmag;
  logic                f_dneg;
  logic                f_sing;

  logic                h_valid_q, h_valid_d;
  m3i_idx_t            h_cnt_q, h_cnt_d;
  logic [MW-1:0]       h_mag_q [NUM_ELEM];
  logic [NUM_ELEM-1:0] h_sgn_q;
  logic [GW-1:0]       h_dmag_q;
  logic                h_dneg_q;
  logic                h_sing_q;

  logic     adv;
  logic     last_issue;
  logic     f_en;
  logic     load;
  m3i_tag_t div_tag;
  logic [NW-1:0] div_num;

  logic          d_valid;
  logic [NW-1:0] d_quot;
  m3i_tag_t      d_tag;

  logic [QXW-1:0]   qx;
  logic [QXW-1:0]   lim_pos;
  logic [QXW-1:0]   lim_neg;
  logic [OUT_W-1:0] sat_val;

  logic             out_valid_q, out_valid_d;
  logic [OUT_W-1:0] out_q [NUM_ELEM];
  logic             sing_q;

  assign a_vec[0] = a_r0c0_i;
  assign a_vec[1] = a_r0c1_i;
  assign a_vec[2] = a_r0c2_i;
  assign a_vec[3] = a_r1c0_i;
  assign a_vec[4] = a_r1c1_i;
  assign a_vec[5] = a_r1c2_i;
  assign a_vec[6] = a_r2c0_i;
  assign a_vec[7] = a_r2c1_i;
  assign a_vec[8] = a_r2c2_i;

  // Whole pipeline holds while a finished result is stalled
  assign adv        = !(out_valid_q && out_stall_i);
  assign last_issue = h_valid_q && (h_cnt_q == LAST_IDX);
  assign f_en       = adv && (!h_valid_q || last_issue);
  assign load       = f_en && f_valid;
  assign in_stall_o = !f_en;

  m3i_front #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (f_en),
    .valid_i(in_valid_i),
    .a_i    (a_vec),
    .valid_o(f_valid),
    .mag_o  (f_mag),
    .sgn_o  (f_sgn),
    .dmag_o (f_dmag),
    .dneg_o (f_dneg),
    .sing_o (f_sing)
  );

  // Issue holding register and element counter
  always_comb begin
    h_valid_d = h_valid_q;
    h_cnt_d   = h_cnt_q;
    if (adv) begin
      if (load) begin
        h_valid_d = 1'b1;
        h_cnt_d   = '0;
      end else if (last_issue) begin
        h_valid_d = 1'b0;
        h_cnt_d   = '0;
      end else if (h_valid_q) begin
        h_cnt_d   = h_cnt_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_valid_q <= 1'b0;
      h_cnt_q   <= '0;
    end else begin
      h_valid_q <= h_valid_d;
      h_cnt_q   <= h_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      h_mag_q  <= f_mag;
      h_sgn_q  <= f_sgn;
      h_dmag_q <= f_dmag;
      h_dneg_q <= f_dneg;
      h_sing_q <= f_sing;
    end
  end

  // One adjugate entry per cycle into the divider while the pipeline is not stalled
  always_comb begin
    div_num      = NW'(h_mag_q[h_cnt_q]) << FRAC_BITS;
    div_tag.idx  = h_cnt_q;
    div_tag.last = (h_cnt_q == LAST_IDX);
    div_tag.qneg = h_sgn_q[h_cnt_q] ^ h_dneg_q;
    div_tag.sing = h_sing_q;
  end

  m3i_div #(
    .NUM_W(NW),
    .DEN_W(GW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .valid_i(h_valid_q),
    .num_i  (div_num),
    .den_i  (h_dmag_q),
    .tag_i  (div_tag),
    .valid_o(d_valid),
    .quot_o (d_quot),
    .tag_o  (d_tag)
  );

  // Sign, saturation and singular override
  always_comb begin
    qx      = QXW'(d_quot);
    lim_pos = QXW'(OUT_MAX);
    lim_neg = lim_pos + QXW'(1);
    if (d_tag.sing) begin
      sat_val = '0;
    end else if (d_tag.qneg) begin
      sat_val = (qx > lim_neg) ? lim_neg[OUT_W-1:0] : (-qx[OUT_W-1:0]);
    end else begin
      sat_val = (qx > lim_pos) ? OUT_MAX : qx[OUT_W-1:0];
    end
  end

  // Result collection
  always_comb begin
    out_valid_d = out_valid_q;
    if (adv && d_valid && d_tag.last) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && d_valid) begin
      out_q[d_tag.idx] <= sat_val;
      if (d_tag.last) begin
        sing_q <= d_tag.sing;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign inv_r0c0_o  = out_q[0];
  assign inv_r0c1_o  = out_q[1];
  assign inv_r0c2_o  = out_q[2];
  assign inv_r1c0_o  = out_q[3];
  assign inv_r1c1_o  = out_q[4];
  assign inv_r1c2_o  = out_q[5];
  assign inv_r2c0_o  = out_q[6];
  assign inv_r2c1_o  = out_q[7];
  assign inv_r2c2_o  = out_q[8];
  assign singular_o  = sing_q;

`ifndef NO_ASSERTIONS
  // A singular result carries only zero elements; the diagonal and the two anti-diagonal corners are checked
  a_sing_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && singular_o) |->
      (inv_r0c0_o == '0) && (inv_r1c1_o == '0) && (inv_r2c2_o == '0) &&
      (inv_r0c2_o == '0) && (inv_r2c0_o == '0))
    else $error("singular result with nonzero element");

  // Issue counter stays within the nine entries while holding a matrix
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    h_valid_q |-> (h_cnt_q <= LAST_IDX))
    else $error("issue counter out of range");

  // The last quotient of a matrix always presents a result next cycle
  a_last_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && d_valid && d_tag.last) |=> out_valid_o)
    else $error("last quotient did not produce a result");
`endif

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import m3i_pkg::*;

  localparam int DW     = 16;
  localparam int FB     = 16;
  localparam int N_RAND = 1430;
  localparam int CALM   = 200;
  localparam int WDOG   = 4000;

  typedef logic signed [DW-1:0] elem_t;
  typedef logic signed [OUT_W-1:0] fix_t;

  typedef struct {
    elem_t a [NUM_ELEM];
  } matrix_t;

  typedef struct {
    fix_t inv [NUM_ELEM];
    logic sing;
  } inverse_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic out_stall_i = 1'b0;
  logic in_stall_o, out_valid_o, singular_o;
  elem_t a_i [NUM_ELEM];
  fix_t inv_o [NUM_ELEM];

  matrix_t  pending_q [$];
  inverse_t expected_q [$];
  int  n_sent = 0, n_recv = 0, n_sing = 0, n_err = 0;
  int  idle_cnt = 0;
  bit  stim_done = 0, calm = 0, drain_hold = 0;
  int  src_gap = 0, snk_gap = 0;

  initial begin
    for (int k = 0; k < NUM_ELEM; k++) a_i[k] = '0;
  end

  always #5 clk_i = ~clk_i;

  matrix3x3_inverse #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) uut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .a_r0c0_i(a_i[0]), .a_r0c1_i(a_i[1]), .a_r0c2_i(a_i[2]),
    .a_r1c0_i(a_i[3]), .a_r1c1_i(a_i[4]), .a_r1c2_i(a_i[5]),
    .a_r2c0_i(a_i[6]), .a_r2c1_i(a_i[7]), .a_r2c2_i(a_i[8]),
    .out_valid_o, .out_stall_i,
    .inv_r0c0_o(inv_o[0]), .inv_r0c1_o(inv_o[1]), .inv_r0c2_o(inv_o[2]),
    .inv_r1c0_o(inv_o[3]), .inv_r1c1_o(inv_o[4]), .inv_r1c2_o(inv_o[5]),
    .inv_r2c0_o(inv_o[6]), .inv_r2c1_o(inv_o[7]), .inv_r2c2_o(inv_o[8]),
    .singular_o
  );

  // Inverse by adjugate over determinant, exact wide integer math
  function automatic inverse_t invert(matrix_t m);
    inverse_t r;
    logic signed [127:0] x [NUM_ELEM];
    logic signed [127:0] cof [NUM_ELEM];
    logic signed [127:0] det, num, q, lim_hi, lim_lo;
    for (int k = 0; k < NUM_ELEM; k++) x[k] = m.a[k];
    cof[0] =   x[4]*x[8] - x[7]*x[5];
    cof[1] = -(x[3]*x[8] - x[6]*x[5]);
    cof[2] =   x[3]*x[7] - x[6]*x[4];
    cof[3] = -(x[1]*x[8] - x[7]*x[2]);
    cof[4] =   x[0]*x[8] - x[6]*x[2];
    cof[5] = -(x[0]*x[7] - x[6]*x[1]);
    cof[6] =   x[1]*x[5] - x[4]*x[2];
    cof[7] = -(x[0]*x[5] - x[3]*x[2]);
    cof[8] =   x[0]*x[4] - x[3]*x[1];
    det = x[0]*cof[0] + x[1]*cof[1] + x[2]*cof[2];
    r.sing = (det == 0);
    lim_hi = (128'sd1 <<< (OUT_W-1)) - 1;
    lim_lo = -(128'sd1 <<< (OUT_W-1));
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        if (r.sing) begin
          r.inv[i*3+j] = '0;
        end else begin
          num = cof[j*3+i] <<< FB;
          q = num / det;  // SV signed division truncates toward zero
          if (q > lim_hi) q = lim_hi;
          if (q < lim_lo) q = lim_lo;
          r.inv[i*3+j] = q[OUT_W-1:0];
        end
      end
    return r;
  endfunction

  function automatic elem_t rand_elem(int mode);
    case (mode)
      0: return elem_t'($urandom);
      1: return elem_t'(int'($urandom_range(0, 15)) - 8);
      2: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      default: return elem_t'(int'($urandom_range(0, 511)) - 256);
    endcase
  endfunction

  task automatic add_matrix(matrix_t m);
    pending_q.push_back(m);
  endtask

  // Stimulus: directed corners first, then random matrices
  initial begin
    matrix_t m;
    int mode;
    // identity
    for (int k = 0; k < NUM_ELEM; k++) m.a[k] = (k % 4 == 0) ? 16'sd1 : 16'sd0;
    add_matrix(m);
    // negative identity: negative quotients
    for (int k = 0; k < NUM_ELEM; k++) m.a[k] = (k % 4 == 0) ? -16'sd1 : 16'sd0;
    add_matrix(m);
    // all zero and all equal: zero determinant
    for (int k = 0; k < NUM_ELEM; k++) m.a[k] = 16'sd0;
    add_matrix(m);
    for (int k = 0; k < NUM_ELEM; k++) m.a[k] = 16'sh7fff;
    add_matrix(m);
    for (int k = 0; k < NUM_ELEM; k++) m.a[k] = 16'sh8000;
    add_matrix(m);
    // large diagonal: quotient magnitude 2, negative and positive
    for (int k = 0; k < NUM_ELEM; k++) m.a[k] = (k % 4 == 0) ? 16'sh8000 : 16'sd0;
    add_matrix(m);
    for (int k = 0; k < NUM_ELEM; k++) m.a[k] = (k % 4 == 0) ? 16'sh7fff : 16'sd0;
    add_matrix(m);
    // det of magnitude 1 or 2^15 with large cofactors: large quotients of both signs
    m.a = '{16'sh7fff, 16'sh7ffe, 16'sd0, 16'sh7ffe, 16'sh7ffd, 16'sd0, 16'sd0, 16'sd0, 16'sd1};
    add_matrix(m);
    m.a = '{16'sh7fff, 16'sh7ffe, 16'sh7fff, 16'sh7ffe, 16'sh7ffd, 16'sh7fff,
            16'sh8000, 16'sh8000, 16'sh8000};
    add_matrix(m);
    m.a = '{16'sh8000, 16'sh7fff, 16'sd0, 16'sh7fff, 16'sh8002, 16'sd0,
            16'sd0, 16'sd0, -16'sd1};
    add_matrix(m);
    // mixed extremes, det largest in magnitude
    m.a = '{16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff,
            16'sh7fff, 16'sh7fff, 16'sh8000};
    add_matrix(m);
    // small matrices: two well-conditioned, one singular
    m.a = '{16'sd2, 16'sd0, 16'sd0, 16'sd0, 16'sd3, 16'sd0, 16'sd0, 16'sd0, 16'sd7};
    add_matrix(m);
    m.a = '{16'sd1, 16'sd2, 16'sd3, 16'sd0, 16'sd1, 16'sd4, 16'sd5, 16'sd6, 16'sd0};
    add_matrix(m);
    m.a = '{16'sd1, 16'sd2, 16'sd3, 16'sd4, 16'sd5, 16'sd6, 16'sd7, 16'sd8, 16'sd9};
    add_matrix(m);
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int n = 0; n < N_RAND; n++) begin
      // pause once until every result is back
      if (n == N_RAND / 2) begin
        wait (pending_q.size() == 0);
        drain_hold = 1;
        wait (expected_q.size() == 0);
        drain_hold = 0;
      end
      mode = $urandom_range(0, 3);
      for (int k = 0; k < NUM_ELEM; k++) m.a[k] = rand_elem(mode);
      // occasional dependent rows for singular cases
      if ($urandom_range(0, 9) == 0)
        for (int k = 0; k < 3; k++) m.a[6+k] = m.a[k];
      add_matrix(m);
      if (n == N_RAND - CALM) calm = 1;
      while (pending_q.size() > 4) @(posedge clk_i);
    end
    stim_done = 1;
  end

  // Driver: request side with random gaps
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        expected_q.push_back(invert(pending_q.pop_front()));
        n_sent <= n_sent + 1;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (src_gap > 0) begin
          src_gap <= src_gap - 1;
          in_valid_i <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
          src_gap <= $urandom_range(0, 9);
          in_valid_i <= 1'b0;
        end else if (pending_q.size() > 0 && !drain_hold) begin
          in_valid_i <= 1'b1;
          for (int k = 0; k < NUM_ELEM; k++)
            a_i[k] <= pending_q[0].a[k];
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Sink stall bursts
  always @(posedge clk_i) begin
    if (snk_gap > 0) begin
      snk_gap <= snk_gap - 1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      snk_gap <= $urandom_range(0, 9);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Monitor: compare each result with the oldest expectation
  always @(posedge clk_i) begin
    inverse_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_recv <= n_recv + 1;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result", $time);
        n_err <= n_err + 1;
      end else begin
        e = expected_q.pop_front();
        if (e.sing) n_sing <= n_sing + 1;
        if (singular_o !== e.sing) begin
          $display("%0t: singular exp %0b got %0b", $time, e.sing, singular_o);
          n_err <= n_err + 1;
        end
        for (int k = 0; k < NUM_ELEM; k++)
          if (inv_o[k] !== e.inv[k]) begin
            $display("%0t: inv[%0d][%0d] exp %0d got %0d", $time, k / 3, k % 3,
                     e.inv[k], inv_o[k]);
            n_err <= n_err + 1;
          end
      end
    end
  end

  // Watchdog on cycles with no handshake
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WDOG) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // End of run
  initial begin
    wait (stim_done && pending_q.size() == 0 && !in_valid_i);
    wait (expected_q.size() == 0);
    repeat (120) @(posedge clk_i);
    $display("Sent %0d matrices, checked %0d inverses, %0d singular.", n_sent, n_recv,
             n_sing);
    if (n_err == 0 && expected_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
